/* hw/rtl/jpsr_pkg.sv */
// Shared types and constants for the joypad serial packet receiver.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none
package jpsr_pkg;

	// Packet geometry
	localparam int PACKET_BITS = 128;
	localparam int BITPOS_W    = $clog2(PACKET_BITS);
	localparam logic [BITPOS_W-1:0] LAST_BIT = BITPOS_W'(PACKET_BITS - 1);

	// Controller selection
	localparam int PAD_SEL_W = 2;
	localparam int PAD_CNT_W = 3;
	localparam logic [PAD_CNT_W-1:0] MAX_PADS = 3'd4;

	// Transfer bookkeeping
	localparam int BLK_W = 3;
	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_SET_PADS = 5'h11;

	// Port register values and masks
	localparam logic [7:0] PORT_START  = 8'hcf;
	localparam logic [7:0] PORT_IDLE   = 8'hff;
	localparam logic [7:0] READ_HI     = 8'hc0;
	localparam logic [7:0] SEL_KEEP    = 8'hf0;

	// Select-line patterns, bits 5:4 of the port
	localparam logic [1:0] LINES_BOTH_LOW  = 2'b00;
	localparam logic [1:0] LINES_LOW4      = 2'b10;
	localparam logic [1:0] LINES_LOW5      = 2'b01;
	localparam logic [1:0] LINES_BOTH_HIGH = 2'b11;

	// Function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MULTI_MODE = 1'b0;

	typedef struct packed {
		logic       func;
		logic [7:0] write_value;
		logic [7:0] pad0_buttons;
		logic [7:0] pad1_buttons;
		logic [7:0] pad2_buttons;
		logic [7:0] pad3_buttons;
	} req_word_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic             packet_done;
		logic [63:0]      packet_low;
		logic [63:0]      packet_high;
		logic [CMD_W-1:0] command_code;
		logic [BLK_W-1:0] block_index;
	} rsp_word_t;

endpackage
`default_nettype wire

/* hw/rtl/jpsr_cfg.sv */
// APB-style configuration register for the packet receiver.
// Depends on jpsr_pkg.
`default_nettype none
module jpsr_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jpsr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [jpsr_pkg::PDATA_W-1:0] pwdata,
	output logic      [jpsr_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output logic                              multi_mode
);
	import jpsr_pkg::*;

	logic multi_mode_q;
	logic wr_en;

	// write strobe on the access phase
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_mode_q <= 1'b1;
		end else if (wr_en && paddr[2] == REG_MULTI_MODE) begin
			multi_mode_q <= pwdata[0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MULTI_MODE) begin
			prdata[0] = multi_mode_q;
		end
	end

	assign multi_mode = multi_mode_q;

endmodule
`default_nettype wire

/* hw/rtl/jpsr_engine.sv */
// Port state, packet shift buffer and per-word result logic.
// Depends on jpsr_pkg.
`default_nettype none
module jpsr_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire jpsr_pkg::req_word_t item,
	input  wire logic                multi_mode,
	output jpsr_pkg::rsp_word_t      result
);
	import jpsr_pkg::*;

	logic                 recv_q, recv_d;
	logic [BITPOS_W-1:0]  bitpos_q, bitpos_d;
	logic [PACKET_BITS-1:0] buf_q, buf_d;
	logic [7:0]           port_q, port_d;
	logic [CMD_W-1:0]     cmd_q, cmd_d;
	logic [BLK_W-1:0]     exp_q, exp_d;
	logic [BLK_W-1:0]     rcvd_q, rcvd_d;
	logic [PAD_CNT_W-1:0] cnt_q, cnt_d;
	logic [PAD_SEL_W-1:0] sel_q, sel_d;
	logic [1:0]           seen_q, seen_d;

	always_comb begin
		logic [1:0]           lines;
		logic [7:0]           pad;
		logic [2:0]           shift;
		logic [3:0]           byte_i;
		logic [BLK_W-1:0]     blk;
		logic [BLK_W-1:0]     nblk;
		logic [PAD_CNT_W-1:0] ncnt;
		logic [PAD_CNT_W-1:0] sinc;
		logic [PAD_SEL_W-1:0] snew;

		lines  = item.write_value[5:4];
		shift  = bitpos_q[2:0];
		byte_i = bitpos_q[BITPOS_W-1:3];
		blk    = rcvd_q;
		nblk   = '0;
		ncnt   = '0;
		sinc   = '0;
		snew   = sel_q;
		pad    = item.pad0_buttons;

		recv_d   = recv_q;
		bitpos_d = bitpos_q;
		buf_d    = buf_q;
		port_d   = port_q;
		cmd_d    = cmd_q;
		exp_d    = exp_q;
		rcvd_d   = rcvd_q;
		cnt_d    = cnt_q;
		sel_d    = sel_q;
		seen_d   = seen_q;
		result   = '0;

		case (sel_q)
			2'd0:    pad = item.pad0_buttons;
			2'd1:    pad = item.pad1_buttons;
			2'd2:    pad = item.pad2_buttons;
			default: pad = item.pad3_buttons;
		endcase

		if (item.func == FUNC_READ) begin
			// port read: id, direction nibble, key nibble or raw port
			if (multi_mode && port_q[5:4] == LINES_BOTH_HIGH) begin
				result.read_data = PORT_IDLE - {6'd0, sel_q};
			end else if (!port_q[5]) begin
				result.read_data = READ_HI | (port_q & SEL_KEEP) | {4'd0, pad[3:0]};
			end else if (!port_q[4]) begin
				result.read_data = READ_HI | (port_q & SEL_KEEP) | {4'd0, pad[7:4]};
			end else begin
				result.read_data = port_q;
			end
		end else if (lines == LINES_BOTH_LOW) begin
			// start pulse, also restarts a packet in flight
			recv_d   = 1'b1;
			bitpos_d = '0;
			port_d   = PORT_START;
		end else if (recv_q) begin
			port_d = item.write_value;
			if (shift == 3'd0) begin
				buf_d[{byte_i, 3'b000} +: 8] = 8'd0;
			end
			if (port_q[5:4] == LINES_BOTH_LOW && lines != LINES_BOTH_HIGH) begin
				// bit pulse right after start: abort
				recv_d = 1'b0;
			end else if (lines != LINES_BOTH_HIGH) begin
				// bit 4 low shifts 0, bit 5 low shifts 1
				buf_d[bitpos_q] = buf_d[bitpos_q] | item.write_value[4];
				if (bitpos_q == LAST_BIT) begin
					if (blk == '0) begin
						cmd_d = buf_d[7:3];
						exp_d = (buf_d[2:0] == 3'd0) ? 3'd1 : buf_d[2:0];
					end
					if (cmd_d == CMD_SET_PADS) begin
						ncnt = {1'b0, buf_d[9:8]} + 3'd1;
						if (ncnt > MAX_PADS) begin
							ncnt = MAX_PADS;
						end
						cnt_d = ncnt;
						sel_d = (ncnt > 3'd1) ? 2'd1 : 2'd0;
					end
					result.packet_done  = 1'b1;
					result.packet_low   = buf_d[63:0];
					result.packet_high  = buf_d[127:64];
					result.command_code = cmd_d;
					result.block_index  = blk;
					recv_d   = 1'b0;
					bitpos_d = '0;
					nblk     = blk + 3'd1;
					if (nblk == exp_d) begin
						exp_d = '0;
						nblk  = '0;
					end
					rcvd_d = nblk;
				end else begin
					bitpos_d = bitpos_q + 1'b1;
				end
			end
		end else if (lines == LINES_BOTH_HIGH) begin
			// idle release: advance pad after both single-line patterns
			if (seen_q == 2'b11) begin
				sinc = {1'b0, sel_q} + 3'd1;
				snew = (sinc >= cnt_q) ? 2'd0 : sinc[PAD_SEL_W-1:0];
				seen_d = 2'b00;
			end
			sel_d  = snew;
			port_d = PORT_IDLE - {6'd0, snew};
		end else begin
			port_d = item.write_value | PORT_START;
			seen_d = seen_q | ((lines == LINES_LOW5) ? 2'b01 : 2'b10);
		end
	end

	// state update once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q   <= 1'b0;
			bitpos_q <= '0;
			buf_q    <= '0;
			port_q   <= PORT_IDLE;
			cmd_q    <= '0;
			exp_q    <= '0;
			rcvd_q   <= '0;
			cnt_q    <= 3'd1;
			sel_q    <= '0;
			seen_q   <= '0;
		end else if (fire) begin
			recv_q   <= recv_d;
			bitpos_q <= bitpos_d;
			buf_q    <= buf_d;
			port_q   <= port_d;
			cmd_q    <= cmd_d;
			exp_q    <= exp_d;
			rcvd_q   <= rcvd_d;
			cnt_q    <= cnt_d;
			sel_q    <= sel_d;
			seen_q   <= seen_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/joypad_serial_packet_receiver_core.sv */
// Joypad serial packet receiver: a word is registered in the input register on
// acceptance, then processed and held in the result register once that is free.
// Throughput is one word per cycle while rsp_stall is low. A stalled result holds
// the result register and stalls the input once the input register is also full.
// Reset (arst_n low, asynchronous) empties both stages, clears the packet
// state, sets the port to 0xff, the controller count to 1 and multi mode on.
`default_nettype none
module joypad_serial_packet_receiver_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire jpsr_pkg::req_word_t          req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output jpsr_pkg::rsp_word_t               rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [jpsr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [jpsr_pkg::PDATA_W-1:0] pwdata,
	output logic      [jpsr_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import jpsr_pkg::*;

	logic      s1_valid_q;
	req_word_t req_s1;
	logic      s2_valid_q;
	rsp_word_t rsp_s2;
	rsp_word_t result;
	logic      multi_mode;
	logic      s2_free;
	logic      advance;

	jpsr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.multi_mode (multi_mode)
	);

	jpsr_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.item       (req_s1),
		.multi_mode (multi_mode),
		.result     (result)
	);

	// handshake between the two stages
	assign s2_free   = !s2_valid_q || !rsp_stall;
	assign advance   = s1_valid_q && s2_free;
	assign req_stall = s1_valid_q && !s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!req_stall) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = s2_valid_q;
	assign rsp       = rsp_s2;

endmodule
`default_nettype wire

/* hw/rtl/jpsr_checker.sv */
// Port-level checks for the joypad serial packet receiver, bound to the top.
// Depends on jpsr_pkg and joypad_serial_packet_receiver_core.
`default_nettype none
module jpsr_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_stall,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_stall,
	input wire jpsr_pkg::rsp_word_t          rsp
);
	import jpsr_pkg::*;

	// a held result word keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// input only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without output back-pressure");

	// an accepted word leaves a result present once it has passed the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> ##2 rsp_valid)
		else $error("no result after accepted word");

	// packet fields are zero unless a packet completed
	a_packet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.packet_done |-> rsp.packet_low == '0 &&
			rsp.packet_high == '0 && rsp.command_code == '0 && rsp.block_index == '0)
		else $error("packet fields set without a completed packet");

endmodule

bind joypad_serial_packet_receiver_core jpsr_checker u_jpsr_checker (.*);
`default_nettype wire

/* verif/tb_joypad_serial_packet_receiver_core.sv */
`timescale 1ns / 1ps
// Testbench for joypad_serial_packet_receiver_core: directed port accesses, then
// random select-line packet transfers and port noise, every result word checked.
// Depends on jpsr_pkg and the core RTL only.
module tb_joypad_serial_packet_receiver_core;
	import jpsr_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 250;
	localparam int TRANSFER_ROOM = 100;
	localparam int PACKET_ITEMS  = 150;
	localparam int MAX_PRINTED   = 200;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	req_word_t           req;
	logic                rsp_valid;
	logic                rsp_stall;
	rsp_word_t           rsp;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	joypad_serial_packet_receiver_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Pending port accesses and the result words they should produce
	req_word_t port_access_q[$];
	rsp_word_t port_result_q[$];
	rsp_word_t predicted;
	rsp_word_t due;
	int        sender_idle_pct;
	int        receiver_stall_pct;
	int        queued_items;
	int        mismatch_count;
	int        cycle_count;
	logic      req_taken;

	// Receiver state as the predictor sees it
	bit        mm_enable;
	bit        rx_active;
	bit [6:0]  bit_pos;
	bit [7:0]  pkt_bytes [16];
	bit [7:0]  port_reg;
	bit [4:0]  cur_cmd;
	bit [2:0]  blocks_expected;
	bit [2:0]  blocks_done;
	bit [2:0]  pad_count;
	bit [1:0]  sel_pad;
	bit [1:0]  lines_seen;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the result word of one port access and advance the state
	task automatic predict_port_access(input req_word_t w, output rsp_word_t r);
		bit [7:0] val;
		bit [7:0] pad;
		bit [7:0] old;
		bit [1:0] lines;
		bit [2:0] shift_n;
		bit [2:0] blk;
		bit [2:0] len;
		bit [3:0] idx;
		int       pos;
		int       cnt;
		int       nxt;
		r = '0;
		val = w.write_value;
		lines = val[5:4];
		if (w.func == FUNC_READ) begin
			case (sel_pad)
				2'd0: pad = w.pad0_buttons;
				2'd1: pad = w.pad1_buttons;
				2'd2: pad = w.pad2_buttons;
				default: pad = w.pad3_buttons;
			endcase
			if (mm_enable && port_reg[5:4] == LINES_BOTH_HIGH) begin
				r.read_data = PORT_IDLE - 8'(sel_pad);
			end else if (!port_reg[5]) begin
				r.read_data = READ_HI | (port_reg & SEL_KEEP) | {4'h0, pad[3:0]};
			end else if (!port_reg[4]) begin
				r.read_data = READ_HI | (port_reg & SEL_KEEP) | {4'h0, pad[7:4]};
			end else begin
				r.read_data = port_reg;
			end
		end else if (lines == LINES_BOTH_LOW) begin
			// start pulse, also restarts a packet in progress
			rx_active = 1'b1;
			bit_pos = '0;
			port_reg = PORT_START;
		end else if (rx_active) begin
			old = port_reg;
			shift_n = bit_pos[2:0];
			idx = bit_pos[6:3];
			port_reg = val;
			if (shift_n == 3'd0)
				pkt_bytes[idx] = '0;
			if (old[5:4] == LINES_BOTH_LOW && lines != LINES_BOTH_HIGH) begin
				// the write right after a start must release both lines
				rx_active = 1'b0;
			end else if (lines != LINES_BOTH_HIGH) begin
				// bit 4 low carries a zero, bit 5 low a one
				pkt_bytes[idx][shift_n] = pkt_bytes[idx][shift_n] | val[4];
				pos = int'(bit_pos) + 1;
				if (pos >= PACKET_BITS) begin
					blk = blocks_done;
					if (blk == 3'd0) begin
						len = pkt_bytes[0][2:0];
						cur_cmd = pkt_bytes[0][7:3];
						blocks_expected = (len == 3'd0) ? 3'd1 : len;
					end
					if (cur_cmd == CMD_SET_PADS) begin
						cnt = int'(pkt_bytes[1][1:0]) + 1;
						if (cnt > int'(MAX_PADS))
							cnt = int'(MAX_PADS);
						pad_count = 3'(cnt);
						sel_pad = (cnt > 1) ? 2'd1 : 2'd0;
					end
					r.packet_done = 1'b1;
					for (int i = 0; i < 8; i++) begin
						r.packet_low[8*i +: 8] = pkt_bytes[i];
						r.packet_high[8*i +: 8] = pkt_bytes[8+i];
					end
					r.command_code = cur_cmd;
					r.block_index = blk;
					rx_active = 1'b0;
					bit_pos = '0;
					blk = blk + 3'd1;
					if (blk == blocks_expected) begin
						blocks_expected = '0;
						blk = '0;
					end
					blocks_done = blk;
				end else begin
					bit_pos = 7'(pos);
				end
			end
		end else if (lines == LINES_BOTH_HIGH) begin
			// both single-line patterns seen: step to the next controller
			if (lines_seen == 2'b11) begin
				nxt = int'(sel_pad) + 1;
				if (nxt >= int'(pad_count))
					nxt = 0;
				sel_pad = 2'(nxt);
				lines_seen = '0;
			end
			port_reg = PORT_IDLE - 8'(sel_pad);
		end else begin
			port_reg = val | PORT_START;
			lines_seen = lines_seen | ((lines == LINES_LOW5) ? 2'b01 : 2'b10);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		// keep the log readable when everything is broken
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Stimulus builders
	task automatic queue_access(input logic f, input logic [7:0] v, input logic [7:0] p0,
			input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] p3);
		req_word_t w;
		w.func = f;
		w.write_value = v;
		w.pad0_buttons = p0;
		w.pad1_buttons = p1;
		w.pad2_buttons = p2;
		w.pad3_buttons = p3;
		port_access_q.push_back(w);
		queued_items++;
	endtask

	task automatic queue_random(input logic f, input logic [7:0] v);
		queue_access(f, v, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic queue_lines(input logic [1:0] lines);
		logic [7:0] v;
		v = 8'($urandom);
		v[5:4] = lines;
		queue_random(FUNC_WRITE, v);
	endtask

	// bit writes may follow each other directly; the release is optional
	task automatic queue_pulse_bit(input logic b);
		queue_lines(b ? LINES_LOW5 : LINES_LOW4);
		if ($urandom_range(11) == 0)
			queue_random(FUNC_READ, 8'($urandom));
		if ($urandom_range(3) == 0)
			queue_lines(LINES_BOTH_HIGH);
	endtask

	task automatic queue_packet(input logic [127:0] bits);
		queue_lines(LINES_BOTH_LOW);
		queue_lines(LINES_BOTH_HIGH);
		for (int i = 0; i < PACKET_BITS; i++)
			queue_pulse_bit(bits[i]);
	endtask

	// One command transfer; some packets are cut short by an abort or a restart
	task automatic queue_transfer(input int max_blocks);
		logic [127:0] bits;
		logic [4:0]   cmd;
		logic [2:0]   len;
		int           blocks;
		int           cut;
		cmd = ($urandom_range(1) == 0) ? CMD_SET_PADS : 5'($urandom);
		len = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
		blocks = (len == 3'd0) ? 1 : int'(len);
		if (blocks > max_blocks)
			blocks = max_blocks;
		for (int p = 0; p < blocks; p++) begin
			bits = {$urandom, $urandom, $urandom, $urandom};
			if (p == 0)
				bits[7:0] = {cmd, len};
			if ($urandom_range(99) < 15) begin
				cut = $urandom_range(PACKET_BITS - 1);
				queue_lines(LINES_BOTH_LOW);
				queue_lines(LINES_BOTH_HIGH);
				for (int i = 0; i < cut; i++)
					queue_pulse_bit(bits[i]);
				if ($urandom_range(1)) begin
					queue_lines(LINES_BOTH_LOW);
					queue_lines($urandom_range(1) ? LINES_LOW4 : LINES_LOW5);
				end
			end
			queue_packet(bits);
		end
	endtask

	task automatic fill_random(input int target);
		int pick;
		int room;
		while (queued_items < target) begin
			pick = $urandom_range(99);
			room = target - queued_items;
			if (pick < 55 && room >= TRANSFER_ROOM) begin
				queue_transfer(1 + (room - TRANSFER_ROOM) / PACKET_ITEMS);
			end else if (pick < 85) begin
				// select-line patterns that cycle the controller, with reads
				repeat ($urandom_range(12, 4)) begin
					case ($urandom_range(3))
						0: queue_random(FUNC_READ, 8'($urandom));
						1: queue_lines(LINES_LOW4);
						2: queue_lines(LINES_LOW5);
						default: queue_lines(LINES_BOTH_HIGH);
					endcase
				end
			end else begin
				repeat ($urandom_range(8, 3))
					queue_random(1'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic wait_drained;
		while (port_access_q.size() != 0 || req_valid || port_result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_multi_mode(input bit enable);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= PADDR_W'(4 * int'(REG_MULTI_MODE));
		pwdata <= PDATA_W'(enable);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		mm_enable = enable;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Driver: next word at the falling edge once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (port_access_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				req <= port_access_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_stall <= arst_n && ($urandom_range(99) < receiver_stall_pct);
	end

	// Monitor: predict accepted words, check returned words
	always @(posedge clk) begin
		req_taken <= req_valid && !req_stall;
		if (req_valid && !req_stall) begin
			predict_port_access(req, predicted);
			port_result_q.push_back(predicted);
		end
		if (rsp_valid && !rsp_stall) begin
			if (port_result_q.size() == 0) begin
				report_mismatch("unexpected word", 64'(rsp.read_data), 64'd0);
			end else begin
				due = port_result_q.pop_front();
				if (rsp.read_data !== due.read_data)
					report_mismatch("read_data", 64'(rsp.read_data), 64'(due.read_data));
				if (rsp.packet_done !== due.packet_done)
					report_mismatch("packet_done", 64'(rsp.packet_done), 64'(due.packet_done));
				if (rsp.packet_low !== due.packet_low)
					report_mismatch("packet_low", rsp.packet_low, due.packet_low);
				if (rsp.packet_high !== due.packet_high)
					report_mismatch("packet_high", rsp.packet_high, due.packet_high);
				if (rsp.command_code !== due.command_code)
					report_mismatch("command_code", 64'(rsp.command_code),
						64'(due.command_code));
				if (rsp.block_index !== due.block_index)
					report_mismatch("block_index", 64'(rsp.block_index), 64'(due.block_index));
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** joypad_serial_packet_receiver_core: FAILED **");
			$finish;
		end
	end

	// Sequence: reset, directed words, then four phases of random words with varied idling and stalls
	initial begin
		int idle_tbl [4];
		int stall_tbl [4];
		int mark;
		idle_tbl = '{0, 62, 0, 34};
		stall_tbl = '{0, 0, 62, 34};
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_taken = 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		queued_items = 0;
		mismatch_count = 0;
		cycle_count = 0;
		mm_enable = 1'b1;
		rx_active = 1'b0;
		bit_pos = '0;
		for (int i = 0; i < 16; i++)
			pkt_bytes[i] = '0;
		port_reg = PORT_IDLE;
		cur_cmd = '0;
		blocks_expected = '0;
		blocks_done = '0;
		pad_count = 3'd1;
		sel_pad = '0;
		lines_seen = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_multi_mode(ph % 2 == 0);
			sender_idle_pct = idle_tbl[ph];
			receiver_stall_pct = stall_tbl[ph];
			if (ph == 0) begin
				// reads in every port state, pad cycling, abort and restart
				queue_access(FUNC_READ, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
				queue_access(FUNC_WRITE, 8'hdf, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'hff, 8'h5a, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hef, 8'hff, 8'hff, 8'hff, 8'hff);
				queue_access(FUNC_READ, 8'h00, 8'ha5, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
				queue_access(FUNC_WRITE, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'h00, 8'h3c, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'h00, 8'hc3, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hcf, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hef, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'hdf, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'h00, 8'h96, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_WRITE, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
				queue_access(FUNC_WRITE, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
				queue_access(FUNC_READ, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
			end
			mark = queued_items;
			fill_random(mark + PHASE_ITEMS / 2);
			// hold off until the block has returned everything
			wait_drained();
			fill_random(mark + PHASE_ITEMS);
		end
		wait_drained();

		if (mismatch_count == 0) begin
			$display("** joypad_serial_packet_receiver_core: PASSED **");
		end else begin
			$display("** joypad_serial_packet_receiver_core: FAILED **");
		end
		$finish;
	end

endmodule
